>>> sv/mf3_pkg.sv
// ----------------------------------------------------------------------------
// mf3_pkg
// Types, constants and compare helpers shared by the 3x3 median filter.
// ----------------------------------------------------------------------------
`default_nettype none

package mf3_pkg;

   localparam int PIX_W      = 8;
   localparam int CFG_W      = 11;
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int CMP_W      = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;
   localparam int ROW_W      = $clog2(MAX_HEIGHT) + 1;
   localparam int OUT_ROW_W  = $clog2(MAX_HEIGHT);
   localparam int CSR_IDX_W  = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;

   localparam logic [CFG_W-1:0] RESET_WIDTH  = 11'd640;
   localparam logic [CFG_W-1:0] RESET_HEIGHT = 11'd480;

   localparam logic ACT_PIXEL = 1'b0;
   localparam logic ACT_FLUSH = 1'b1;

   typedef struct packed {
      logic             action;
      logic [PIX_W-1:0] pixel_value;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0] median_value;
      logic             last_of_frame;
   } rsp_type;

   // one window column, sorted low to high
   typedef struct packed {
      logic [PIX_W-1:0] lo;
      logic [PIX_W-1:0] md;
      logic [PIX_W-1:0] hi;
   } col_type;

   // request state between the line store read and column build
   typedef struct packed {
      logic valid;
      logic emit;
      logic last;
      logic left_clamp;
      logic right_clamp;
      logic top_clamp;
      logic bot_clamp;
      logic bank;
   } col_ctl_type;

   typedef struct packed {
      logic valid;
      logic last;
   } res_ctl_type;

   function automatic logic [PIX_W-1:0] min2(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b);
      return (a < b) ? a : b;
   endfunction

   function automatic logic [PIX_W-1:0] max2(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b);
      return (a < b) ? b : a;
   endfunction

   function automatic logic [PIX_W-1:0] min3(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b,
                                             logic [PIX_W-1:0] c);
      return min2(min2(a, b), c);
   endfunction

   function automatic logic [PIX_W-1:0] max3(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b,
                                             logic [PIX_W-1:0] c);
      return max2(max2(a, b), c);
   endfunction

   function automatic logic [PIX_W-1:0] med3(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b,
                                             logic [PIX_W-1:0] c);
      return max2(min2(a, b), min2(max2(a, b), c));
   endfunction

   function automatic col_type sort3(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b,
                                     logic [PIX_W-1:0] c);
      logic [PIX_W-1:0] lo_ab;
      logic [PIX_W-1:0] hi_ab;
      logic [PIX_W-1:0] up;
      col_type          res;
      lo_ab  = min2(a, b);
      hi_ab  = max2(a, b);
      up     = max2(lo_ab, c);
      res.lo = min2(lo_ab, c);
      res.md = min2(hi_ab, up);
      res.hi = max2(hi_ab, up);
      return res;
   endfunction

endpackage

`default_nettype wire

>>> sv/median_filter_3x3_stream_top.sv
// ----------------------------------------------------------------------------
// median_filter_3x3_stream_top
// 3x3 median over a raster 8-bit frame, edges replicated, two line memories.
//
//   port group  dir  handshake          payload
//   req_*       in   req_valid/ready    req_data  (action, pixel_value)
//   rsp_*       out  rsp_valid/ready    rsp_data  (median_value, last_of_frame)
//   csr_*       in   csr_we             csr_index, csr_wdata
//
// One request per clock; the single read-first access to the line memories
// per request sets that rate. A result is valid once the request that completes
// its window is accepted and has passed the memory read at the accepting edge,
// the column sort into the first median stage, then the final median stage.
// A stalled rsp holds the whole pipe and drops req_ready.
// Reset clears positions and selects 640x480; line memories are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module median_filter_3x3_stream_top (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_ready,
   input  mf3_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  wire                                 rsp_ready,
   output mf3_pkg::rsp_type                    rsp_data,
   input  wire                                 csr_we,
   input  wire  [mf3_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire  [mf3_pkg::CFG_W-1:0]           csr_wdata
);

   localparam int CMP_W = mf3_pkg::CMP_W;
   localparam int ROW_W = mf3_pkg::ROW_W;

   logic [mf3_pkg::CFG_W-1:0]     width_ff;
   logic [mf3_pkg::CFG_W-1:0]     height_ff;
   logic [mf3_pkg::COL_W-1:0]     in_col_ff,  in_col_in;
   logic [ROW_W-1:0]              in_row_ff,  in_row_in;
   logic [mf3_pkg::COL_W-1:0]     out_col_ff, out_col_in;
   logic [mf3_pkg::OUT_ROW_W-1:0] out_row_ff, out_row_in;
   mf3_pkg::col_ctl_type          b_ctl_ff,   b_ctl_in;
   logic [mf3_pkg::PIX_W-1:0]     b_pixel_ff;
   mf3_pkg::col_type              v1_ff;
   mf3_pkg::col_type              v2_ff;

   logic [CMP_W-1:0]          w_eff;
   logic [ROW_W-1:0]          h_eff;
   logic                      advance;
   logic                      accept;
   logic                      in_data_row;
   logic                      ignore;
   logic                      go;
   logic                      col_wrap;
   logic                      emit;
   logic                      out_col_last;
   logic                      out_row_last;
   logic                      frame_last;
   logic                      csr_hit;
   logic [mf3_pkg::PIX_W-1:0] rd_even;
   logic [mf3_pkg::PIX_W-1:0] rd_odd;
   logic [mf3_pkg::PIX_W-1:0] top_pix;
   logic [mf3_pkg::PIX_W-1:0] mid_pix;
   logic [mf3_pkg::PIX_W-1:0] bot_pix;
   mf3_pkg::col_type          v0;
   mf3_pkg::col_type          col_left;
   mf3_pkg::col_type          col_right;
   mf3_pkg::res_ctl_type      med_in_ctl;
   mf3_pkg::res_ctl_type      med_out_ctl;
   logic [mf3_pkg::PIX_W-1:0] median;

   // effective frame size
   always_comb begin
      if (width_ff == '0) begin
         w_eff = CMP_W'(1);
      end else if (CMP_W'(width_ff) > CMP_W'(mf3_pkg::MAX_WIDTH)) begin
         w_eff = CMP_W'(mf3_pkg::MAX_WIDTH);
      end else begin
         w_eff = CMP_W'(width_ff);
      end
      if (height_ff == '0) begin
         h_eff = ROW_W'(1);
      end else if (ROW_W'(height_ff) > ROW_W'(mf3_pkg::MAX_HEIGHT)) begin
         h_eff = ROW_W'(mf3_pkg::MAX_HEIGHT);
      end else begin
         h_eff = ROW_W'(height_ff);
      end
   end

   assign advance   = !med_out_ctl.valid || rsp_ready;
   assign req_ready = advance;
   assign accept    = req_valid && advance;

   assign in_data_row  = in_row_ff < h_eff;
   assign ignore       = (req_data.action == mf3_pkg::ACT_FLUSH) && in_data_row;
   assign go           = accept && !ignore;
   assign col_wrap     = CMP_W'(in_col_ff) == w_eff - CMP_W'(1);
   assign emit         = (in_row_ff > ROW_W'(1)) ||
                         ((in_row_ff == ROW_W'(1)) && (in_col_ff != '0));
   assign out_col_last = CMP_W'(out_col_ff) == w_eff - CMP_W'(1);
   assign out_row_last = ROW_W'(out_row_ff) == h_eff - ROW_W'(1);
   assign frame_last   = out_col_last && out_row_last;
   assign csr_hit      = csr_we && ((csr_index == mf3_pkg::CSR_IMAGE_WIDTH) ||
                                    (csr_index == mf3_pkg::CSR_IMAGE_HEIGHT));

   // position tracking
   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (csr_hit || (go && emit && frame_last)) begin
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
      end else if (go) begin
         if (col_wrap) begin
            in_col_in = '0;
            in_row_in = in_row_ff + ROW_W'(1);
         end else begin
            in_col_in = in_col_ff + mf3_pkg::COL_W'(1);
         end
         if (emit) begin
            if (out_col_last) begin
               out_col_in = '0;
               out_row_in = out_row_ff + mf3_pkg::OUT_ROW_W'(1);
            end else begin
               out_col_in = out_col_ff + mf3_pkg::COL_W'(1);
            end
         end
      end
   end

   always_comb begin
      b_ctl_in = b_ctl_ff;
      if (advance) begin
         b_ctl_in.valid       = go;
         b_ctl_in.emit        = emit;
         b_ctl_in.last        = frame_last;
         b_ctl_in.left_clamp  = out_col_ff == '0;
         b_ctl_in.right_clamp = out_col_last;
         b_ctl_in.top_clamp   = in_row_ff == ROW_W'(1);
         b_ctl_in.bot_clamp   = !in_data_row;
         b_ctl_in.bank        = in_row_ff[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= mf3_pkg::RESET_WIDTH;
         height_ff  <= mf3_pkg::RESET_HEIGHT;
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         b_ctl_ff   <= '0;
      end else begin
         if (csr_we && (csr_index == mf3_pkg::CSR_IMAGE_WIDTH)) begin
            width_ff <= csr_wdata;
         end
         if (csr_we && (csr_index == mf3_pkg::CSR_IMAGE_HEIGHT)) begin
            height_ff <= csr_wdata;
         end
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         b_ctl_ff   <= b_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         b_pixel_ff <= req_data.pixel_value;
      end
   end

   mf3_line_store u_line_store (
      .clock   (clock),
      .en      (go),
      .we      (in_data_row),
      .bank    (in_row_ff[0]),
      .addr    (in_col_ff),
      .wdata   (req_data.pixel_value),
      .rd_even (rd_even),
      .rd_odd  (rd_odd)
   );

   // column build: the bank holding the current row has the row two above
   always_comb begin
      mid_pix   = b_ctl_ff.bank ? rd_even : rd_odd;
      top_pix   = b_ctl_ff.top_clamp ? mid_pix : (b_ctl_ff.bank ? rd_odd : rd_even);
      bot_pix   = b_ctl_ff.bot_clamp ? mid_pix : b_pixel_ff;
      v0        = mf3_pkg::sort3(top_pix, mid_pix, bot_pix);
      col_left  = b_ctl_ff.left_clamp  ? v1_ff : v2_ff;
      col_right = b_ctl_ff.right_clamp ? v1_ff : v0;
      med_in_ctl.valid = b_ctl_ff.valid && b_ctl_ff.emit;
      med_in_ctl.last  = b_ctl_ff.last;
   end

   always_ff @(posedge clock) begin
      if (advance && b_ctl_ff.valid) begin
         v1_ff <= v0;
         v2_ff <= v1_ff;
      end
   end

   mf3_median u_median (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_ctl     (med_in_ctl),
      .col_left   (col_left),
      .col_center (v1_ff),
      .col_right  (col_right),
      .out_ctl    (med_out_ctl),
      .median     (median)
   );

   assign rsp_valid              = med_out_ctl.valid;
   assign rsp_data.median_value  = median;
   assign rsp_data.last_of_frame = med_out_ctl.last;

   a_col_in_frame : assert property (@(posedge clock) disable iff (reset)
      CMP_W'(in_col_ff) < w_eff)
      else $error("input column outside frame width");

   a_out_row_in_frame : assert property (@(posedge clock) disable iff (reset)
      ROW_W'(out_row_ff) < h_eff)
      else $error("output row outside frame height");

   a_drain_bounded : assert property (@(posedge clock) disable iff (reset)
      in_row_ff <= h_eff + ROW_W'(1))
      else $error("drain ran past the frame");

   a_stall_holds_pipe : assert property (@(posedge clock) disable iff (reset)
      (b_ctl_ff.valid && !advance) |=> b_ctl_ff.valid)
      else $error("column stage lost a request while stalled");

endmodule

`default_nettype wire

>>> sv/mf3_line_store.sv
// ----------------------------------------------------------------------------
// mf3_line_store
// Two line memories, rows alternating by parity. Read-first: one access per
// request returns the two stored rows at the column and writes the new pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module mf3_line_store (
   input  wire                            clock,
   input  wire                            en,
   input  wire                            we,
   input  wire                            bank,
   input  wire  [mf3_pkg::COL_W-1:0]      addr,
   input  wire  [mf3_pkg::PIX_W-1:0]      wdata,
   output logic [mf3_pkg::PIX_W-1:0]      rd_even,
   output logic [mf3_pkg::PIX_W-1:0]      rd_odd
);

   logic [mf3_pkg::PIX_W-1:0] even_line_ff [mf3_pkg::MAX_WIDTH];
   logic [mf3_pkg::PIX_W-1:0] odd_line_ff  [mf3_pkg::MAX_WIDTH];
   logic [mf3_pkg::PIX_W-1:0] rd_even_ff;
   logic [mf3_pkg::PIX_W-1:0] rd_odd_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         rd_even_ff <= even_line_ff[addr];
         if (we && !bank) begin
            even_line_ff[addr] <= wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rd_odd_ff <= odd_line_ff[addr];
         if (we && bank) begin
            odd_line_ff[addr] <= wdata;
         end
      end
   end

   assign rd_even = rd_even_ff;
   assign rd_odd  = rd_odd_ff;

endmodule

`default_nettype wire

>>> sv/mf3_median.sv
// ----------------------------------------------------------------------------
// mf3_median
// Median of nine from three sorted columns, two register stages:
// max of lows / median of middles / min of highs, then median of those three.
// ----------------------------------------------------------------------------
`default_nettype none

module mf3_median (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            advance,
   input  mf3_pkg::res_ctl_type           in_ctl,
   input  mf3_pkg::col_type               col_left,
   input  mf3_pkg::col_type               col_center,
   input  mf3_pkg::col_type               col_right,
   output mf3_pkg::res_ctl_type           out_ctl,
   output logic [mf3_pkg::PIX_W-1:0]      median
);

   mf3_pkg::res_ctl_type      mid_ctl_ff;
   mf3_pkg::res_ctl_type      out_ctl_ff;
   logic [mf3_pkg::PIX_W-1:0] lo_ff;
   logic [mf3_pkg::PIX_W-1:0] md_ff;
   logic [mf3_pkg::PIX_W-1:0] hi_ff;
   logic [mf3_pkg::PIX_W-1:0] median_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_ctl_ff <= '0;
         out_ctl_ff <= '0;
      end else if (advance) begin
         mid_ctl_ff <= in_ctl;
         out_ctl_ff <= mid_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         lo_ff     <= mf3_pkg::max3(col_left.lo, col_center.lo, col_right.lo);
         md_ff     <= mf3_pkg::med3(col_left.md, col_center.md, col_right.md);
         hi_ff     <= mf3_pkg::min3(col_left.hi, col_center.hi, col_right.hi);
         median_ff <= mf3_pkg::med3(lo_ff, md_ff, hi_ff);
      end
   end

   assign out_ctl = out_ctl_ff;
   assign median  = median_ff;

endmodule

`default_nettype wire

>>> tb/sv/median_filter_3x3_stream_top_tb.sv
// ----------------------------------------------------------------------------
// median_filter_3x3_stream_top_tb
// Self-checking bench for the streaming 3x3 median filter. A short table of
// directed requests and register writes covers the edge cases. Random frames
// follow: mostly small, some with wider rows, some with stray flushes or
// cut short. A behavioral filter predicts every result. Both handshakes
// idle at random.
// ----------------------------------------------------------------------------
module median_filter_3x3_stream_top_tb;

   localparam int PIX_W      = mf3_pkg::PIX_W;
   localparam int CFG_W      = mf3_pkg::CFG_W;
   localparam int CSR_IDX_W  = mf3_pkg::CSR_IDX_W;
   localparam int MAX_WIDTH  = mf3_pkg::MAX_WIDTH;
   localparam int MAX_HEIGHT = mf3_pkg::MAX_HEIGHT;

   localparam int SETTLE_CYCLES = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_3 = 2'd3;

   typedef enum logic {ROW_REQ, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type           kind;
      logic [CSR_IDX_W-1:0]   idx;
      logic [CFG_W-1:0]       val;
      logic                   act;
      logic [PIX_W-1:0]       pix;
      logic                   fixed;
      logic [PIX_W-1:0]       med;
      logic                   last;
   } step_row_type;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   mf3_pkg::req_type       req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   mf3_pkg::rsp_type       rsp_data;
   logic                   csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [CFG_W-1:0]       csr_wdata = '0;

   // filter state as seen by the predictor
   logic [CFG_W-1:0]   cfg_width  = mf3_pkg::RESET_WIDTH;
   logic [CFG_W-1:0]   cfg_height = mf3_pkg::RESET_HEIGHT;
   bit [PIX_W-1:0]     ring_rows [4][MAX_WIDTH];
   int unsigned        in_col, in_row, out_count, out_row, out_col;

   mf3_pkg::rsp_type   median_q [$];
   mf3_pkg::rsp_type   oldest;
   int                 fails    = 0;
   int                 taken    = 0;
   int                 rsp_hold = 0;
   bit                 calm_req = 1'b0;
   bit                 calm_rsp = 1'b0;

   step_row_type script [29] = '{
      '{ROW_REQ, '0, '0, mf3_pkg::ACT_FLUSH, 8'h00, 1'b0, 8'h00, 1'b0},
      '{ROW_CSR, mf3_pkg::CSR_IMAGE_WIDTH, 11'd1, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0},
      '{ROW_CSR, mf3_pkg::CSR_IMAGE_HEIGHT, 11'd1, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0},
      '{ROW_REQ, '0, '0, mf3_pkg::ACT_PIXEL, 8'hFF, 1'b0, 8'h00, 1'b0},
      '{ROW_REQ, '0, '0, mf3_pkg::ACT_FLUSH, 8'h00, 1'b0, 8'h00, 1'b0},
      '{ROW_REQ, '0, '0, mf3_pkg::ACT_FLUSH, 8'h00, 1'b1, 8'hFF, 1'b1},
      '{ROW_REQ, '0, '0, mf3_pkg::ACT_FLUSH, 8'h00, 1'b0, 8'h00, 1'b0},
      '{ROW_REQ, '0, '0, mf3_pkg::ACT_PIXEL, 8'h00, 1'b0, 8'h00, 1'b0},
      '{ROW_REQ, '0, '0, mf3_pkg::ACT_PIXEL, 8'hAA, 1'b0, 8'h00, 1'b0},
      '{ROW_REQ, '0, '0, mf3_pkg::ACT_FLUSH, 8'h00, 1'b1, 8'h00, 1'b1},
      '{ROW_CSR, mf3_pkg::CSR_IMAGE_WIDTH, 11'd0, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0},
      '{ROW_CSR, mf3_pkg::CSR_IMAGE_HEIGHT, 11'd0, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0},
      '{ROW_REQ, '0, '0, mf3_pkg::ACT_PIXEL, 8'h81, 1'b0, 8'h00, 1'b0},
      '{ROW_REQ, '0, '0, mf3_pkg::ACT_PIXEL, 8'h7E, 1'b0, 8'h00, 1'b0},
      '{ROW_REQ, '0, '0, mf3_pkg::ACT_FLUSH, 8'h00, 1'b1, 8'h81, 1'b1},
      '{ROW_CSR, mf3_pkg::CSR_IMAGE_WIDTH, 11'd3, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0},
      '{ROW_CSR, mf3_pkg::CSR_IMAGE_HEIGHT, 11'd2, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0},
      '{ROW_REQ, '0, '0, mf3_pkg::ACT_PIXEL, 8'h10, 1'b0, 8'h00, 1'b0},
      '{ROW_REQ, '0, '0, mf3_pkg::ACT_PIXEL, 8'hF0, 1'b0, 8'h00, 1'b0},
      '{ROW_CSR, CSR_SPARE_2, 11'h7FF, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0},
      '{ROW_CSR, CSR_SPARE_3, 11'h000, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0},
      '{ROW_REQ, '0, '0, mf3_pkg::ACT_PIXEL, 8'h33, 1'b0, 8'h00, 1'b0},
      '{ROW_REQ, '0, '0, mf3_pkg::ACT_PIXEL, 8'hCC, 1'b0, 8'h00, 1'b0},
      '{ROW_REQ, '0, '0, mf3_pkg::ACT_PIXEL, 8'h55, 1'b0, 8'h00, 1'b0},
      '{ROW_REQ, '0, '0, mf3_pkg::ACT_PIXEL, 8'h01, 1'b0, 8'h00, 1'b0},
      '{ROW_REQ, '0, '0, mf3_pkg::ACT_FLUSH, 8'h00, 1'b0, 8'h00, 1'b0},
      '{ROW_REQ, '0, '0, mf3_pkg::ACT_PIXEL, 8'h80, 1'b0, 8'h00, 1'b0},
      '{ROW_REQ, '0, '0, mf3_pkg::ACT_FLUSH, 8'h00, 1'b0, 8'h00, 1'b0},
      '{ROW_REQ, '0, '0, mf3_pkg::ACT_FLUSH, 8'h00, 1'b0, 8'h00, 1'b0}
   };

   median_filter_3x3_stream_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int unsigned frame_dim(logic [CFG_W-1:0] v, int unsigned top);
      if (v == 0) return 1;
      if (v > top) return top;
      return v;
   endfunction

   function automatic int unsigned clamp_to(int v, int unsigned n);
      if (v < 0) return 0;
      if (v >= int'(n)) return n - 1;
      return v;
   endfunction

   function automatic void restart_position();
      in_col    = 0;
      in_row    = 0;
      out_count = 0;
      out_row   = 0;
      out_col   = 0;
   endfunction

   task automatic predict_median(input mf3_pkg::req_type item, output bit made,
                                 output mf3_pkg::rsp_type res);
      int unsigned     w, h, p;
      int              dr, dc, i, j, lt, le;
      logic [8:0][7:0] win;
      w    = frame_dim(cfg_width, MAX_WIDTH);
      h    = frame_dim(cfg_height, MAX_HEIGHT);
      made = 1'b0;
      res  = '0;
      if (in_col >= w) in_col = 0;
      p = in_row * w + in_col;
      // a flush inside the frame is dropped without moving the position
      if (in_row >= h || item.action != mf3_pkg::ACT_FLUSH) begin
         if (in_row < h) ring_rows[in_row % 4][in_col] = item.pixel_value;
         taken++;
         in_col++;
         if (in_col >= w) begin
            in_col = 0;
            in_row++;
         end
         if (p >= w + 1) begin
            for (dr = 0; dr < 3; dr++)
               for (dc = 0; dc < 3; dc++)
                  win[dr * 3 + dc] = ring_rows[clamp_to(int'(out_row) + dr - 1, h) % 4]
                                              [clamp_to(int'(out_col) + dc - 1, w)];
            for (i = 0; i < 9; i++) begin
               lt = 0;
               le = 0;
               for (j = 0; j < 9; j++) begin
                  if (win[j] < win[i]) lt++;
                  if (win[j] <= win[i]) le++;
               end
               if (lt <= 4 && le >= 5) res.median_value = win[i];
            end
            res.last_of_frame = (out_count + 1 >= w * h);
            made = 1'b1;
            if (res.last_of_frame) begin
               restart_position();
            end else begin
               out_count++;
               out_col++;
               if (out_col >= w) begin
                  out_col = 0;
                  out_row++;
               end
            end
         end
      end
   endtask

   task automatic send_request(input mf3_pkg::req_type item, input bit fixed,
                               input mf3_pkg::rsp_type fixed_rsp);
      int               gap;
      bit               made;
      mf3_pkg::rsp_type got;
      gap = calm_req ? 0 : $urandom_range(0, 13);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      predict_median(item, made, got);
      if (made) median_q.push_back(fixed ? fixed_rsp : got);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (median_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == mf3_pkg::CSR_IMAGE_WIDTH) begin
         cfg_width = val;
         restart_position();
      end else if (idx == mf3_pkg::CSR_IMAGE_HEIGHT) begin
         cfg_height = val;
         restart_position();
      end
      @(posedge clock);
   endtask

   task automatic run_frame(input logic [CFG_W-1:0] w_reg, input logic [CFG_W-1:0] h_reg,
                            input bit whole);
      int unsigned w, h, pixels, stop_at, pause_at, pix_top, i;
      wait_drained();
      if ($urandom_range(0, 4) == 0)
         write_csr($urandom_range(0, 1) ? CSR_SPARE_2 : CSR_SPARE_3, CFG_W'($urandom));
      write_csr(mf3_pkg::CSR_IMAGE_WIDTH, w_reg);
      write_csr(mf3_pkg::CSR_IMAGE_HEIGHT, h_reg);
      calm_req = ($urandom_range(0, 3) == 0);
      calm_rsp = ($urandom_range(0, 3) == 0);
      w        = frame_dim(w_reg, MAX_WIDTH);
      h        = frame_dim(h_reg, MAX_HEIGHT);
      pixels   = w * h;
      stop_at  = pixels + w + 1;
      if (!whole && $urandom_range(0, 5) == 0) stop_at = $urandom_range(0, stop_at - 1);
      pause_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, stop_at) : stop_at + 1;
      pix_top  = ($urandom_range(0, 3) == 0) ? 3 : 255;
      for (i = 0; i < stop_at; i++) begin
         if (i == pause_at) wait_drained();
         if (i < pixels) begin
            if ($urandom_range(0, 15) == 0)
               send_request({mf3_pkg::ACT_FLUSH, PIX_W'($urandom)}, 1'b0, '0);
            send_request({mf3_pkg::ACT_PIXEL, PIX_W'($urandom_range(0, pix_top))},
                         1'b0, '0);
         end else begin
            send_request({1'($urandom), PIX_W'($urandom)}, 1'b0, '0);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (median_q.size() == 0) begin
               $error("unexpected result: median_value=%0d last_of_frame=%0d",
                      rsp_data.median_value, rsp_data.last_of_frame);
               fails++;
            end else begin
               oldest = median_q.pop_front();
               if (rsp_data.median_value !== oldest.median_value) begin
                  $error("median_value: expected %0d, got %0d",
                         oldest.median_value, rsp_data.median_value);
                  fails++;
               end
               if (rsp_data.last_of_frame !== oldest.last_of_frame) begin
                  $error("last_of_frame: expected %0d, got %0d",
                         oldest.last_of_frame, rsp_data.last_of_frame);
                  fails++;
               end
            end
            rsp_hold = calm_rsp ? 0 : $urandom_range(0, 13);
         end else if (rsp_hold != 0) begin
            rsp_hold--;
         end
         rsp_ready <= (rsp_hold == 0);
      end
   end

   initial begin
      mf3_pkg::req_type step_req;
      mf3_pkg::rsp_type step_rsp;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         if (script[i].kind == ROW_CSR) begin
            wait_drained();
            write_csr(script[i].idx, script[i].val);
         end else begin
            step_req = {script[i].act, script[i].pix};
            step_rsp = {script[i].med, script[i].last};
            send_request(step_req, script[i].fixed, step_rsp);
         end
      end

      while (taken < 950) begin
         if ($urandom_range(0, 7) == 0)
            run_frame(CFG_W'($urandom_range(13, 80)), CFG_W'($urandom_range(1, 3)), 1'b0);
         else
            run_frame(CFG_W'($urandom_range(0, 12)), CFG_W'($urandom_range(0, 8)), 1'b0);
      end

      // one last frame run to completion
      run_frame(CFG_W'(12), CFG_W'(8), 1'b1);

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fails == 0)
         $display("PASS median_filter_3x3_stream_top");
      else
         $display("FAIL median_filter_3x3_stream_top");
      $finish;
   end

   initial begin
      #8000000;
      $display("FAIL median_filter_3x3_stream_top");
      $finish;
   end

endmodule
